### sv/npsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npsd_pkg: shared types and constants
// Function codes, register indexes, reset values and the cell/control structs.
// ----------------------------------------------------------------------------
package npsd_pkg;

	localparam int WORD_W = 24;
	localparam int CNT_W  = 8;

	// item function codes
	localparam logic [1:0] FUNC_NOTE_ON = 2'd0;
	localparam logic [1:0] FUNC_TICK    = 2'd1;
	localparam logic [1:0] FUNC_CLEAR   = 2'd2;
	localparam logic [1:0] FUNC_RSVD    = 2'd3;

	// register indexes
	localparam logic [1:0] REG_BASE_NOTE = 2'd0;
	localparam logic [1:0] REG_MIN_TICKS = 2'd1;
	localparam logic [1:0] REG_RANGE     = 2'd2;

	// register reset values
	localparam logic [6:0] BASE_NOTE_RST = 7'd79;
	localparam logic [6:0] MIN_TICKS_RST = 7'd10;
	localparam logic [7:0] RANGE_RST     = 8'd60;

	// one channel as it travels around the ring
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             on;
	} cell_t;

	// what the update point does to the entry passing through
	typedef struct packed {
		logic             tick;
		logic             load;
		logic [CNT_W-1:0] len;
	} ctl_t;

endpackage

### sv/npsd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npsd_cell: one ring cell
// Holds one channel's counter and output bit, passes it on while shifting and clears the bit on clr.
// ----------------------------------------------------------------------------
module npsd_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift_en,
	input  logic           clr,
	input  npsd_pkg::cell_t d,
	output npsd_pkg::cell_t q
);
	import npsd_pkg::*;

	cell_t cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (shift_en) begin
			cell_q <= d;
		end else if (clr) begin
			cell_q.on <= 1'b0;
		end
	end

	assign q = cell_q;

endmodule

### sv/npsd_head.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npsd_head: ring update point
// Applies a tick or a note-on load to the entry leaving the last cell.
// ----------------------------------------------------------------------------
module npsd_head (
	input  npsd_pkg::cell_t tail,
	input  npsd_pkg::ctl_t  ctl,
	output npsd_pkg::cell_t upd,
	output logic            expire
);
	import npsd_pkg::*;

	always_comb begin
		upd    = tail;
		expire = 1'b0;
		if (ctl.tick) begin
			if (tail.cnt != '0) begin
				upd.cnt = tail.cnt - CNT_W'(1);
				if (tail.cnt == CNT_W'(1)) begin
					upd.on = 1'b0;
					expire = 1'b1;
				end
			end
		end else if (ctl.load) begin
			upd.cnt = ctl.len;
			upd.on  = 1'b1;
		end
	end

endmodule

### sv/npsd_len.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npsd_len: pulse length pipeline
// min + vel*range/127 saturated at 255, in three register stages.
// ----------------------------------------------------------------------------
module npsd_len (
	input  logic       clk,
	input  logic [6:0] vel,
	input  logic [7:0] range_ticks,
	input  logic [6:0] min_ticks,
	output logic [7:0] len
);
	logic [14:0] p_s1;
	logic [14:0] p_s2;
	logic [7:0]  q_s2;
	logic [7:0]  len_s3;
	logic [24:0] est;
	logic [14:0] back;
	logic [7:0]  fix;
	logic [8:0]  sum;

	// 517/65536 sits just above 1/127: estimate is exact or one high
	assign est  = {10'd0, p_s1} * 25'd517;
	assign back = 15'({7'd0, q_s2} * 15'd127);
	assign fix  = (back > p_s2) ? q_s2 - 8'd1 : q_s2;
	assign sum  = {2'b00, min_ticks} + {1'b0, fix};

	always_ff @(posedge clk) begin
		p_s1   <= {8'd0, vel} * {7'd0, range_ticks};
		p_s2   <= p_s1;
		q_s2   <= est[23:16];
		len_s3 <= sum[8] ? 8'hFF : sum[7:0];
	end

	assign len = len_s3;

endmodule

### sv/note_pulse_shift_driver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_pulse_shift_driver_core: multi-channel one-shot pulse driver
// Note-on starts a per-channel pulse, ticks count it down, words go out.
// ----------------------------------------------------------------------------
// Channel counters and output bits live in a ring of NOTES cells that rotates
// one full turn per note-on or tick item, so every entry passes the single
// update point once and ends back in its home cell. A tick sweeps the ring
// and then emits a word if one is due; a note-on passes states LEN1, LEN2 and
// LEN3 for the length pipeline, then sweeps; a clear emits a word at once; an
// unused function code or an out-of-range note is dropped while idle. Inputs:
// s_tuser carries func, s_tdata carries note_number and velocity. Result
// words go out on m_tdata through an output register, so the next item is
// taken while a word waits; only a second word stalls.
// Config writes (cfg_index 0 base note, 1 minimum pulse ticks, 2 extra
// ticks at full velocity) are always accepted and must come while idle.
// ----------------------------------------------------------------------------
module note_pulse_shift_driver_core #(
	parameter int NOTES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// item input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [6:0] note_number, [13:7] velocity, [15:14] zero
	input  logic [1:0]  s_tuser,   // [1:0] func
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [23:0] output_word
	// config write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import npsd_pkg::*;

	localparam int CW = (NOTES > 1) ? $clog2(NOTES) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LEN1  = 3'd1;
	localparam logic [2:0] ST_LEN2  = 3'd2;
	localparam logic [2:0] ST_LEN3  = 3'd3;
	localparam logic [2:0] ST_SWEEP = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]  state_q;
	logic [1:0]  func_q;
	logic [6:0]  vel_q;
	logic [CW-1:0] ch_q;
	logic [CW-1:0] idx_q;
	logic        pending_q;
	logic        out_valid_q;
	logic [23:0] res_q;

	logic [6:0]  base_note_q;
	logic [6:0]  min_ticks_q;
	logic [7:0]  range_q;

	logic [1:0]  in_func;
	logic [6:0]  in_note;
	logic [6:0]  in_vel;
	logic        s_accept;
	logic [6:0]  diff;
	logic        hit;
	logic        emit_go;
	logic        shift_en;
	logic        clr;
	logic        expire;
	logic [7:0]  len;
	logic [23:0] word_all;
	ctl_t        ctl;
	cell_t       upd;
	cell_t       cell_d [NOTES];
	cell_t       cell_q [NOTES];

	assign in_func  = s_tuser;
	assign in_note  = s_tdata[6:0];
	assign in_vel   = s_tdata[13:7];
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// channel lookup for a note-on
	assign diff = in_note - base_note_q;
	assign hit  = (in_note >= base_note_q) && ({1'b0, diff} < 8'(NOTES));

	assign shift_en = (state_q == ST_SWEEP);
	assign clr      = s_accept && (in_func == FUNC_CLEAR);
	assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || m_tready);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_note_q <= BASE_NOTE_RST;
			min_ticks_q <= MIN_TICKS_RST;
			range_q     <= RANGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE_NOTE: base_note_q <= cfg_data[6:0];
				REG_MIN_TICKS: min_ticks_q <= cfg_data[6:0];
				REG_RANGE:     range_q     <= cfg_data;
				default:       ;
			endcase
		end
	end

	// pulse length, registered in npsd_len from vel_q and the config registers
	npsd_len u_len (
		.clk         (clk),
		.vel         (vel_q),
		.range_ticks (range_q),
		.min_ticks   (min_ticks_q),
		.len         (len)
	);

	// update point at the ring tail
	always_comb begin
		ctl.tick = shift_en && (func_q == FUNC_TICK);
		ctl.load = shift_en && (func_q == FUNC_NOTE_ON) && (idx_q == ch_q);
		ctl.len  = len;
	end

	npsd_head u_head (
		.tail   (cell_q[NOTES-1]),
		.ctl    (ctl),
		.upd    (upd),
		.expire (expire)
	);

	// the ring
	genvar g;
	generate
		for (g = 0; g < NOTES; g++) begin : g_ring
			if (g == 0) begin : g_first
				assign cell_d[g] = upd;
			end else begin : g_next
				assign cell_d[g] = cell_q[g-1];
			end
			npsd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.clr      (clr),
				.d        (cell_d[g]),
				.q        (cell_q[g])
			);
		end
		// output bits; channels past the word have none
		for (g = 0; g < WORD_W; g++) begin : g_word
			if (g < NOTES) begin : g_bit
				assign word_all[g] = cell_q[g].on;
			end else begin : g_zero
				assign word_all[g] = 1'b0;
			end
		end
	endgenerate

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			pending_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						idx_q <= CW'(NOTES - 1);
						priority if (in_func == FUNC_NOTE_ON) begin
							if (hit) begin
								state_q   <= ST_LEN1;
								pending_q <= 1'b1;
							end
						end else if (in_func == FUNC_TICK) begin
							state_q <= ST_SWEEP;
						end else if (in_func == FUNC_CLEAR) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_LEN1: state_q <= ST_LEN2;
				ST_LEN2: state_q <= ST_LEN3;
				ST_LEN3: state_q <= ST_SWEEP;
				ST_SWEEP: begin
					if (expire) begin
						pending_q <= 1'b1;
					end
					if (idx_q == '0) begin
						if ((func_q == FUNC_TICK) && (pending_q || expire)) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q <= idx_q - CW'(1);
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
						if (func_q == FUNC_TICK) begin
							pending_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			func_q <= in_func;
			vel_q  <= in_vel;
			ch_q   <= diff[CW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_q <= word_all;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

	// ring turn counts down one entry per cycle
	a_sweep_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && idx_q != '0) |=>
			(state_q == ST_SWEEP && idx_q == $past(idx_q) - CW'(1)))
		else $error("ring sweep counter slipped");

	// a clear leaves every output bit low for the word it emits
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (state_q == ST_EMIT && word_all == '0))
		else $error("clear did not zero output bits");

	// an emitted tick word consumes the pending mark
	a_pending_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && func_q == FUNC_TICK) |=> (!pending_q && m_tvalid))
		else $error("pending mark not cleared on tick word");

endmodule

### verif/note_pulse_shift_driver_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_pulse_shift_driver_core_tb: self-checking bench for the pulse driver
// Drives note-on, tick, clear and unused items plus register writes. A local
// channel model predicts every emitted output word, and each word taken from
// the block is compared in order. Traffic runs with and without idle cycles.
// ----------------------------------------------------------------------------
module note_pulse_shift_driver_core_tb;
	import npsd_pkg::*;

	localparam int NOTES     = 24;
	localparam int SETTLE_CY = 2 * NOTES + 16;	// covers a note-on or tick still in flight

	logic        clk = 1'b1;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;	// [6:0] note_number, [13:7] velocity, [15:14] zero
	logic [1:0]  s_tuser = FUNC_TICK;	// [1:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;	// [23:0] output_word
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_BASE_NOTE;
	logic [7:0]  cfg_data = '0;

	// channel model
	logic [6:0]        cfg_base_note = BASE_NOTE_RST;
	logic [6:0]        cfg_min_ticks = MIN_TICKS_RST;
	logic [7:0]        cfg_range     = RANGE_RST;
	logic [CNT_W-1:0]  ticks_left [NOTES];
	logic [WORD_W-1:0] lit_bits = '0;
	logic              shift_due = 1'b0;
	logic [WORD_W-1:0] words_due [$];

	int error_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	note_pulse_shift_driver_core #(.NOTES(NOTES)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		for (int i = 0; i < NOTES; i++)
			ticks_left[i] = '0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Apply one accepted item to the channel model; queue the word it emits.
	task automatic advance_channels(input logic [1:0] fn, input logic [6:0] note,
			input logic [6:0] vel);
		int ch;
		int len;
		case (fn)
			FUNC_NOTE_ON: begin
				ch = int'(note) - int'(cfg_base_note);
				if (ch >= 0 && ch < NOTES) begin
					len = int'(cfg_min_ticks) + (int'(vel) * int'(cfg_range)) / 127;
					if (len > 255)
						len = 255;
					if (ch < WORD_W)
						lit_bits[ch] = 1'b1;
					ticks_left[ch] = len[CNT_W-1:0];
					shift_due = 1'b1;
				end
			end
			FUNC_TICK: begin
				for (int i = 0; i < NOTES; i++) begin
					if (ticks_left[i] != 0) begin
						ticks_left[i] = ticks_left[i] - 1'b1;
						if (ticks_left[i] == 0) begin
							if (i < WORD_W)
								lit_bits[i] = 1'b0;
							shift_due = 1'b1;
						end
					end
				end
				if (shift_due) begin
					shift_due = 1'b0;
					words_due.push_back(lit_bits);
				end
			end
			FUNC_CLEAR: begin
				// counters and the pending mark survive a clear
				lit_bits = '0;
				words_due.push_back('0);
			end
			default: ;
		endcase
	endtask

	// Receiver: random backpressure, changed on the falling edge.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Word checker: compare each taken word with the oldest prediction.
	always @(posedge clk) begin
		logic [WORD_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (words_due.size() == 0) begin
				report_mismatch($sformatf("unexpected word %06h", m_tdata));
			end else begin
				want = words_due.pop_front();
				if (m_tdata !== want)
					report_mismatch($sformatf("output_word %06h, predicted %06h",
						m_tdata, want));
			end
		end
	end

	// Entered and left at a falling edge; valid stays high into the next item.
	task automatic send_item(input logic [1:0] fn, input logic [6:0] note,
			input logic [6:0] vel);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {2'b00, vel, note};
		do
			@(posedge clk);
		while (!s_tready);
		advance_channels(fn, note, vel);
		@(negedge clk);
	endtask

	// Stop the stream and wait until every predicted word is out and the ring
	// has finished any item that emits nothing.
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (words_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CY) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_BASE_NOTE: cfg_base_note = value[6:0];
			REG_MIN_TICKS: cfg_min_ticks = value[6:0];
			REG_RANGE:     cfg_range     = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_channel_map(input int first, input int min_t, input int span);
		drain_block();
		write_reg(REG_BASE_NOTE, first[7:0]);
		write_reg(REG_MIN_TICKS, min_t[7:0]);
		write_reg(REG_RANGE, span[7:0]);
	endtask

	// Reset values: ignored items, both word-edge channels, clear vs pending.
	task automatic test_directed_defaults();
		send_item(FUNC_RSVD, 7'd79, 7'd127);	// unused func code
		send_item(FUNC_TICK, 7'd0, 7'd0);	// nothing pending yet
		send_item(FUNC_NOTE_ON, 7'd78, 7'd127);	// just below the map
		send_item(FUNC_NOTE_ON, 7'd103, 7'd127);	// just above the map
		send_item(FUNC_NOTE_ON, 7'd79, 7'd0);	// channel 0, shortest
		send_item(FUNC_NOTE_ON, 7'd102, 7'd127);	// channel 23, longest
		send_item(FUNC_TICK, 7'd127, 7'd127);
		send_item(FUNC_TICK, 7'd0, 7'd0);
		send_item(FUNC_NOTE_ON, 7'd90, 7'd64);
		send_item(FUNC_CLEAR, 7'd0, 7'd0);	// pending mark stays
		send_item(FUNC_TICK, 7'd0, 7'd0);
		send_item(FUNC_NOTE_ON, 7'd0, 7'd127);
		send_item(FUNC_NOTE_ON, 7'd127, 7'd127);
		send_item(FUNC_NOTE_ON, 7'd80, 7'd1);
		repeat (9) send_item(FUNC_TICK, 7'h55, 7'h2a);	// channel 0 times out
		drain_block();
	endtask

	// Register extremes: lowest map with one-tick pulses, highest with 255.
	task automatic test_register_extremes();
		set_channel_map(0, 1, 0);
		send_item(FUNC_NOTE_ON, 7'd0, 7'd127);
		send_item(FUNC_NOTE_ON, 7'd23, 7'd0);
		send_item(FUNC_NOTE_ON, 7'd24, 7'd64);	// off the end of the map
		send_item(FUNC_TICK, 7'd0, 7'd0);
		send_item(FUNC_TICK, 7'd0, 7'd0);
		set_channel_map(127, 127, 128);
		send_item(FUNC_NOTE_ON, 7'd126, 7'd127);	// below the map
		send_item(FUNC_NOTE_ON, 7'd127, 7'd127);	// longest length, 255
		send_item(FUNC_TICK, 7'd0, 7'd0);
		send_item(FUNC_CLEAR, 7'd127, 7'd127);
		send_item(FUNC_RSVD, 7'd0, 7'd0);
		drain_block();
	endtask

	task automatic test_random_traffic(input int count);
		int pick;
		int first;
		logic [6:0] note;
		logic [6:0] vel;
		for (int n = 0; n < count; n++) begin
			pick  = int'($urandom_range(99));
			first = int'(cfg_base_note);
			note  = 7'($urandom_range(127));
			case ($urandom_range(7))
				0:       vel = 7'd0;
				1:       vel = 7'd127;
				default: vel = 7'($urandom_range(127));
			endcase
			if (pick < 52) begin
				send_item(FUNC_TICK, note, vel);
			end else if (pick < 82) begin
				// note that maps to a channel
				note = 7'(first + int'($urandom_range((127 - first < NOTES - 1) ?
					127 - first : NOTES - 1)));
				send_item(FUNC_NOTE_ON, note, vel);
			end else if (pick < 88) begin
				// note off either end of the map
				if (first > 0 && (first + NOTES > 127 || $urandom_range(1)))
					note = 7'($urandom_range(first - 1));
				else
					note = 7'($urandom_range(127, first + NOTES));
				send_item(FUNC_NOTE_ON, note, vel);
			end else if (pick < 95) begin
				send_item(FUNC_CLEAR, note, vel);
			end else if (pick < 97) begin
				send_item(FUNC_RSVD, note, vel);
			end else begin
				send_item(FUNC_NOTE_ON, note, vel);
			end
		end
	endtask

	initial begin
		int idle_mode [4][2];
		int map_set [8][3];
		idle_mode = '{'{0, 0}, '{84, 0}, '{0, 84}, '{33, 33}};
		map_set = '{'{79, 10, 60}, '{0, 1, 0}, '{127, 127, 128}, '{60, 1, 128},
			'{104, 1, 1}, '{13, 127, 0}, '{0, 0, 0}, '{0, 0, 0}};
		// last two settings are drawn at random
		for (int k = 6; k < 8; k++) begin
			map_set[k][0] = int'($urandom_range(110));
			map_set[k][1] = int'($urandom_range(127, 1));
			map_set[k][2] = int'($urandom_range(128));
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_defaults();
		test_register_extremes();
		for (int p = 0; p < 4; p++) begin
			for (int s = 0; s < 2; s++) begin
				send_idle_pct  = idle_mode[p][0];
				recv_stall_pct = idle_mode[p][1];
				set_channel_map(map_set[2*p+s][0], map_set[2*p+s][1], map_set[2*p+s][2]);
				test_random_traffic(210);
			end
		end
		drain_block();

		if (error_count == 0) begin
			$display("note_pulse_shift_driver_core_tb: PASS");
		end else begin
			$display("note_pulse_shift_driver_core_tb: FAIL");
		end
		$finish;
	end

	// Watchdog: the slowest correct run is far below this.
	initial begin
		#10_000_000;
		$display("note_pulse_shift_driver_core_tb: FAIL");
		$finish;
	end

endmodule

### files.f
sv/npsd_pkg.sv
sv/npsd_cell.sv
sv/npsd_head.sv
sv/npsd_len.sv
sv/note_pulse_shift_driver_core.sv
verif/note_pulse_shift_driver_core_tb.sv
